>>> design/gss_pkg.sv
// Shared types and constants for the gate step sequencer.
// Used by gss_core, gate_step_sequencer, gss_checker and tb; no dependencies.
`default_nettype none

package gss_pkg;

  // Default values of the top-level parameters.
  localparam int MAX_STEPS_DEF = 64;
  localparam int TIME_BITS_DEF = 24;

  // Extra lamp time added to the measured gate-high time, in milliseconds.
  localparam int PULSE_EXTRA = 200;

  // Configuration register indexes and widths.
  localparam int CFG_DATA_W  = 64;
  localparam int CFG_INDEX_W = 1;
  localparam logic [CFG_INDEX_W-1:0] REG_STEP_PATTERN = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_STEP_COUNT   = 1'd1;
  localparam int COUNT_W = 7;
  localparam logic [COUNT_W-1:0] STEP_COUNT_RESET = 7'd16;

  // Stream widths.
  localparam int STEP_W   = 6;
  localparam int S_DATA_W = 8;
  localparam int M_DATA_W = 16;

  // One result beat.
  typedef struct packed {
    logic              wrapped;
    logic [STEP_W-1:0] current_step;
    logic              reset_lamp;
    logic              trigger_low;
  } result_t;

endpackage

`default_nettype wire

>>> design/gate_step_sequencer.sv
// Gate step sequencer: each input beat's result is registered and shown as a result beat in the next cycle.
// Throughput one beat per cycle; the input is taken whenever the result register is
// empty or is being emptied in the same cycle, so the rate is set by the output side.
// Reset (rst, synchronous) clears the state, releases the trigger, sets the pattern to
// zero and the step count to sixteen. Depends on gss_pkg and gss_core.
`default_nettype none

module gate_step_sequencer
  import gss_pkg::*;
#(
  parameter int MAX_STEPS = MAX_STEPS_DEF,
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_we,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,
  input  wire logic                   s_tvalid,
  output logic                        s_tready,
  input  wire logic [S_DATA_W-1:0]    s_tdata,   // [0] gate_level
  output logic                        m_tvalid,
  input  wire logic                   m_tready,
  output logic [M_DATA_W-1:0]         m_tdata    // [0] trigger_low, [1] reset_lamp,
                                                 // [7:2] current_step, [8] wrapped
);

  localparam int RES_W = $bits(result_t);

  result_t res;
  logic    s_beat;

  assign s_tready = !m_tvalid || m_tready;
  assign s_beat   = s_tvalid && s_tready;

  gss_core #(
    .MAX_STEPS (MAX_STEPS),
    .TIME_BITS (TIME_BITS)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .step_en    (s_beat),
    .gate_level (s_tdata[0]),
    .res        (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s_beat) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // The result register loads only on an input beat, so a stalled beat holds.
  always_ff @(posedge clk) begin
    if (s_beat) begin
      m_tdata <= {{(M_DATA_W-RES_W){1'b0}}, res};
    end
  end

endmodule

`default_nettype wire

>>> design/gss_core.sv
// Sequencer state and configuration registers; computes the result of one gate sample.
// Depends on gss_pkg.
`default_nettype none

module gss_core
  import gss_pkg::*;
#(
  parameter int MAX_STEPS = MAX_STEPS_DEF,
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_we,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,
  input  wire logic                   step_en,
  input  wire logic                   gate_level,
  output result_t                     res
);

  localparam int IDX_W = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;
  localparam logic [COUNT_W-1:0] MAX_CNT = COUNT_W'(MAX_STEPS);
  localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};

  logic [MAX_STEPS-1:0] step_pattern;
  logic [COUNT_W-1:0]   step_count;

  logic [IDX_W-1:0]     step_index,     step_index_next;
  logic                 edge_seen,      edge_seen_next;
  logic                 trigger_reg,    trigger_reg_next;
  logic [TIME_BITS-1:0] gate_high_time, gate_high_time_next;
  logic [TIME_BITS-1:0] pulse_duration, pulse_duration_next;
  logic [TIME_BITS-1:0] pulse_elapsed,  pulse_elapsed_next;
  logic                 lamp_on,        lamp_on_next;
  logic                 wrap;

  logic [COUNT_W-1:0]   eff_count;
  logic [COUNT_W-1:0]   idx_plus;
  logic [TIME_BITS:0]   ght_sum;
  logic [TIME_BITS:0]   dur_sum;
  logic [TIME_BITS-1:0] ght_inc;

  always_ff @(posedge clk) begin
    if (rst) begin
      step_pattern <= '0;
      step_count   <= STEP_COUNT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_STEP_PATTERN: step_pattern <= cfg_data[MAX_STEPS-1:0];
        REG_STEP_COUNT:   step_count   <= cfg_data[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // A count of zero behaves as one; anything above the step capacity is clamped.
  always_comb begin
    eff_count = step_count;
    if (step_count == '0) eff_count = COUNT_W'(1);
    if (step_count > MAX_CNT) eff_count = MAX_CNT;
  end

  assign idx_plus = COUNT_W'(step_index) + COUNT_W'(1);
  assign ght_sum  = {1'b0, gate_high_time} + (TIME_BITS+1)'(1);
  assign ght_inc  = edge_seen ? (ght_sum[TIME_BITS] ? TIME_MAX : ght_sum[TIME_BITS-1:0])
                              : gate_high_time;
  assign dur_sum  = {1'b0, ght_inc} + (TIME_BITS+1)'(PULSE_EXTRA);

  always_comb begin
    step_index_next     = step_index;
    edge_seen_next      = edge_seen;
    trigger_reg_next    = trigger_reg;
    gate_high_time_next = ght_inc;
    pulse_duration_next = pulse_duration;
    pulse_elapsed_next  = pulse_elapsed;
    lamp_on_next        = lamp_on;
    wrap                = 1'b0;

    // The lamp counts down first; it goes dark once no time is left.
    if (lamp_on) begin
      if (pulse_elapsed == '0) lamp_on_next = 1'b0;
      else pulse_elapsed_next = pulse_elapsed - TIME_BITS'(1);
    end

    if (gate_level) begin
      if (!edge_seen) begin
        gate_high_time_next = '0;
        if (step_pattern[step_index]) trigger_reg_next = 1'b0;
        if (idx_plus >= eff_count) begin
          step_index_next    = '0;
          wrap               = 1'b1;
          lamp_on_next       = 1'b1;
          pulse_elapsed_next = pulse_duration;
        end else begin
          step_index_next = idx_plus[IDX_W-1:0];
        end
        edge_seen_next = 1'b1;
      end
    end else begin
      if (edge_seen) begin
        pulse_duration_next = dur_sum[TIME_BITS] ? TIME_MAX : dur_sum[TIME_BITS-1:0];
      end
      edge_seen_next   = 1'b0;
      trigger_reg_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step_index     <= '0;
      edge_seen      <= 1'b0;
      trigger_reg    <= 1'b1;
      gate_high_time <= '0;
      pulse_duration <= '0;
      pulse_elapsed  <= '0;
      lamp_on        <= 1'b0;
    end else if (step_en) begin
      step_index     <= step_index_next;
      edge_seen      <= edge_seen_next;
      trigger_reg    <= trigger_reg_next;
      gate_high_time <= gate_high_time_next;
      pulse_duration <= pulse_duration_next;
      pulse_elapsed  <= pulse_elapsed_next;
      lamp_on        <= lamp_on_next;
    end
  end

  assign res.trigger_low  = trigger_reg_next;
  assign res.reset_lamp   = lamp_on_next;
  assign res.current_step = STEP_W'(step_index_next);
  assign res.wrapped      = wrap;

endmodule

`default_nettype wire

>>> design/gss_checker.sv
// Port-level checks for gate_step_sequencer, attached by the bind statement below.
// Depends on gss_pkg.
`default_nettype none

module gss_checker
  import gss_pkg::*;
(
  input wire logic                clk,
  input wire logic                rst,
  input wire logic                s_tvalid,
  input wire logic                s_tready,
  input wire logic                m_tvalid,
  input wire logic                m_tready,
  input wire logic [M_DATA_W-1:0] m_tdata
);

  // A result beat appears only after an input beat was taken.
  a_no_invented: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(s_tvalid && s_tready))
    else $error("result beat without an input beat");

  // A wrap always lands on step zero and lights the lamp.
  a_wrap_lamp: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[8]) |-> (m_tdata[7:2] == '0 && m_tdata[1]))
    else $error("wrap without step zero or lamp");

  // The input side is never held off while the result register is empty.
  a_ready_empty: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with empty result register");

  // A stalled result beat keeps its payload.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("stalled result beat changed");

endmodule

bind gate_step_sequencer gss_checker u_gss_checker (.*);

`default_nettype wire

>>> dv/tb.sv
// Self-checking testbench for gate_step_sequencer: directed edge cases, then random gate traffic.
// It keeps its own model of the step sequencer, state and registers, and checks every result beat.
// Depends on gss_pkg and the gate_step_sequencer RTL only.
module tb;
  import gss_pkg::*;

  localparam int STEPS_MAX = MAX_STEPS_DEF;
  localparam int TW        = TIME_BITS_DEF;

  logic                   clk       = 1'b0;
  logic                   rst       = 1'b1;
  logic                   cfg_we    = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = REG_STEP_PATTERN;
  logic [CFG_DATA_W-1:0]  cfg_data  = '0;
  logic                   s_tvalid  = 1'b0;
  logic                   s_tready;
  logic [S_DATA_W-1:0]    s_tdata   = '0;  // [0] gate_level
  logic                   m_tvalid;
  logic                   m_tready  = 1'b0;
  logic [M_DATA_W-1:0]    m_tdata;         // [0] trigger_low, [1] reset_lamp,
                                           // [7:2] current_step, [8] wrapped

  gate_step_sequencer dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Sequencer model: registers and state as they stand after the last accepted sample.
  logic [63:0]        pattern_reg = '0;
  logic [COUNT_W-1:0] count_reg   = STEP_COUNT_RESET;
  logic [STEP_W-1:0]  seq_step    = '0;
  logic               gate_was_high = 1'b0;
  logic               trig_level  = 1'b1;
  logic [TW-1:0]      high_ms     = '0;
  logic [TW-1:0]      lamp_ms     = '0;
  logic [TW-1:0]      lamp_left   = '0;
  logic               lamp_lit    = 1'b0;

  result_t expected_q[$];
  int idle_pct = 0;
  int stall_pct = 0;
  int hold_request = 0;
  int hold_left = 0;
  int mismatch_count = 0;
  int samples_taken = 0;
  int results_checked = 0;
  int wraps_seen = 0;

  function automatic result_t step_gate(input logic gate);
    result_t r;
    logic [COUNT_W-1:0] limit;
    logic [COUNT_W-1:0] nxt;
    logic [TW:0] sum;
    r.wrapped = 1'b0;
    // The lamp times out first, so it goes dark one sample after its time runs out.
    if (lamp_lit) begin
      if (lamp_left == '0) lamp_lit = 1'b0;
      else lamp_left = lamp_left - 1'b1;
    end
    if (gate_was_high && high_ms != '1) high_ms = high_ms + 1'b1;
    if (gate) begin
      if (!gate_was_high) begin
        high_ms = '0;
        if (pattern_reg[seq_step]) trig_level = 1'b0;
        if (count_reg == '0) limit = COUNT_W'(1);
        else if (count_reg > STEPS_MAX) limit = COUNT_W'(STEPS_MAX);
        else limit = count_reg;
        nxt = {1'b0, seq_step} + 1'b1;
        if (nxt >= limit) begin
          nxt = '0;
          r.wrapped = 1'b1;
          lamp_lit = 1'b1;
          lamp_left = lamp_ms;
        end
        seq_step = nxt[STEP_W-1:0];
        gate_was_high = 1'b1;
      end
    end else begin
      if (gate_was_high) begin
        sum = {1'b0, high_ms} + (TW+1)'(PULSE_EXTRA);
        lamp_ms = sum[TW] ? '1 : sum[TW-1:0];
      end
      gate_was_high = 1'b0;
      trig_level = 1'b1;
    end
    r.trigger_low = trig_level;
    r.reset_lamp = lamp_lit;
    r.current_step = seq_step;
    return r;
  endfunction

  // Input monitor: every accepted gate sample yields exactly one expected result beat.
  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) begin
      expected_q.push_back(step_gate(s_tdata[0]));
      samples_taken++;
    end
  end

  // Result checker.
  always @(posedge clk) begin : check_results
    result_t got;
    result_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = result_t'(m_tdata[8:0]);
      results_checked++;
      if (expected_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("%0t: result beat with nothing expected: %h", $time, m_tdata);
      end else begin
        want = expected_q.pop_front();
        if (got.wrapped) wraps_seen++;
        if (got.trigger_low !== want.trigger_low || got.reset_lamp !== want.reset_lamp ||
            got.current_step !== want.current_step || got.wrapped !== want.wrapped) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("%0t: want trig=%0b lamp=%0b step=%0d wrap=%0b, got %0b %0b %0d %0b",
                     $time, want.trigger_low, want.reset_lamp, want.current_step, want.wrapped,
                     got.trigger_low, got.reset_lamp, got.current_step, got.wrapped);
        end
      end
    end
  end

  // Receiver: random stalls, or a long hold-off when a test asks for one.
  always @(posedge clk) begin
    if (hold_request != 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // All tasks below start just after a rising edge.
  task automatic send_sample(input logic gate);
    while ($urandom_range(99) < idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {{(S_DATA_W-1){1'b0}}, gate};
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic send_pulse(input int high_len, input int low_len);
    repeat (high_len) send_sample(1'b1);
    repeat (low_len) send_sample(1'b0);
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_q.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // Writes both registers on consecutive edges; only called while the block is idle.
  task automatic load_sequence(input logic [63:0] pattern, input logic [63:0] count_word);
    cfg_we <= 1'b1;
    cfg_index <= REG_STEP_PATTERN;
    cfg_data <= pattern;
    @(posedge clk);
    pattern_reg = pattern;
    cfg_index <= REG_STEP_COUNT;
    cfg_data <= count_word;
    @(posedge clk);
    count_reg = count_word[COUNT_W-1:0];
    cfg_we <= 1'b0;
  endtask

  // A wrap before any falling edge has a zero-length lamp pulse; bits above the count are ignored.
  task automatic test_first_wrap();
    load_sequence(64'h8000_0000_0000_0001, 64'hFFFF_FFFF_FFFF_FF81);
    send_pulse(1, 1);
    wait_drained();
  endtask

  // A count of zero behaves as one, so every rising edge wraps and restarts the lit lamp.
  task automatic test_count_zero();
    load_sequence(64'h8000_0000_0000_0001, 64'd0);
    send_pulse(1, 1);
    send_pulse(2, 1);
    wait_drained();
  endtask

  // Raising the count past the top is clamped to the full 64 steps, which reaches bit 63.
  task automatic test_full_length();
    load_sequence(64'h8000_0000_0000_0001, 64'd127);
    repeat (STEPS_MAX + 1) send_pulse(1, 1);
    wait_drained();
  endtask

  // Lowering the count under the current index makes the next rising edge wrap.
  task automatic test_count_lowered();
    load_sequence('1, 64'd16);
    repeat (5) send_pulse(1, 1);
    wait_drained();
    load_sequence('1, 64'd3);
    send_pulse(1, 1);
    wait_drained();
  endtask

  // The lamp stays lit for the measured high time plus the fixed margin, then goes dark.
  task automatic test_lamp_expiry();
    load_sequence(64'h0, 64'd2);
    send_pulse(6, 1);
    send_pulse(1, 230);
    wait_drained();
  endtask

  // The receiver holds off long enough for the block to fill and stall its input.
  task automatic test_backpressure();
    idle_pct = 0;
    stall_pct = 0;
    load_sequence({$urandom, $urandom}, 64'd4);
    hold_request = 80;
    repeat (10) send_pulse(2, 2);
    wait_drained();
  endtask

  task automatic test_random_traffic(input int idle, input int stall);
    int sent;
    int kind;
    int len;
    idle_pct = idle;
    stall_pct = stall;
    repeat (2) begin
      if ($urandom_range(99) < 80) load_sequence({$urandom, $urandom}, 64'($urandom_range(1, 12)));
      else load_sequence({$urandom, $urandom}, 64'($urandom_range(0, 127)));
      sent = 0;
      while (sent < 30) begin
        kind = $urandom_range(99);
        if (kind < 72) begin
          len = $urandom_range(1, 8);
          send_pulse(len, $urandom_range(1, 8));
          sent += len + 4;
        end else if (kind < 82) begin
          len = $urandom_range(20, 80);
          send_pulse(len, $urandom_range(1, 4));
          sent += len + 2;
        end else if (kind < 85) begin
          // A long quiet spell can let a lit lamp run out.
          len = $urandom_range(150, 260);
          send_pulse(0, len);
          sent += len;
        end else begin
          len = $urandom_range(1, 6);
          repeat (len) send_sample(1'($urandom_range(1)));
          sent += len;
        end
      end
      wait_drained();
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_first_wrap();
    test_count_zero();
    test_count_lowered();
    test_lamp_expiry();
    test_full_length();
    test_backpressure();
    test_random_traffic(0, 0);
    test_random_traffic(57, 0);
    test_random_traffic(0, 57);
    test_random_traffic(26, 26);
    repeat (4) @(posedge clk);
    $display("Run covered %0d gate samples and %0d result beats (%0d wraps), with count limits,",
             samples_taken, results_checked, wraps_seen);
    $display("lamp expiry, output hold-off and four mixes of input gaps and output stalls.");
    if (mismatch_count == 0) begin
      $display("gate_step_sequencer verification clean");
    end else begin
      $display("%0d mismatches in total", mismatch_count);
      $display("gate_step_sequencer verification failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("gate_step_sequencer verification failed");
    $finish;
  end

endmodule

>>> filelist.f
design/gss_pkg.sv
design/gss_core.sv
design/gate_step_sequencer.sv
design/gss_checker.sv
dv/tb.sv
